FILE: sv/grid_min_path_sum_row_buffer_top_defines.svh
// Assertion macros for the checker file of the grid path sum block.
`ifndef GRID_MIN_PATH_SUM_ROW_BUFFER_TOP_DEFINES_SVH
`define GRID_MIN_PATH_SUM_ROW_BUFFER_TOP_DEFINES_SVH

// Clocked property, muted while reset is held.
`define GMPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked property that is checked during reset too.
`define GMPS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: sv/gmps_pkg.sv
// Package: sizes, register indexes and shared types of the grid path sum block.
package gmps_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;
    localparam int COST_W       = 16;
    localparam int PATH_W       = 23;
    localparam int CFG_W        = 7;
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_COLS = 2'd0,
        CFG_NUM_ROWS = 2'd1
    } t_cfg_idx;

    // Position of the current cell within the grid.
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_col;
        logic last_row;
    } t_pos;

endpackage

FILE: sv/gmps_cell.sv
// One cell of the row buffer shift line: holds one best sum of the row above.
module gmps_cell import gmps_pkg::*; #(
    parameter int WIDTH = 24
) (
    input  logic             i_clk,
    input  logic             i_shift,
    input  logic             i_load,
    input  logic [WIDTH-1:0] i_new,
    input  logic [WIDTH-1:0] i_prev,
    output logic [WIDTH-1:0] o_sum
);

    logic [WIDTH-1:0] r_sum;
    logic [WIDTH-1:0] n_sum;

    // Take the fresh sum at the entry cell, otherwise pass the neighbor's along.
    always_comb begin
        n_sum = r_sum;
        if (i_shift) begin
            n_sum = i_load ? i_new : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

FILE: sv/gmps_pos.sv
// Column and row counters that track where the current cell sits in the grid.
module gmps_pos import gmps_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CEW = $clog2(MAX_COLS + 1),
    localparam int REW = $clog2(MAX_ROWS + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic           i_restart,
    input  logic [CEW-1:0] i_cols,
    input  logic [REW-1:0] i_rows,
    output t_pos           o_pos
);

    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic [RW-1:0] r_row;
    logic [RW-1:0] n_row;

    always_comb begin
        o_pos.first_row = (r_row == '0);
        o_pos.first_col = (r_col == '0);
        o_pos.last_col  = ((CW+1)'(r_col) + (CW+1)'(1)) >= (CW+1)'(i_cols);
        o_pos.last_row  = ((RW+1)'(r_row) + (RW+1)'(1)) >= (RW+1)'(i_rows);
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (i_step) begin
            if (o_pos.last_col) begin
                n_col = '0;
                n_row = o_pos.last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

FILE: sv/grid_min_path_sum_row_buffer_top.sv
// Top level of the minimum down/right path sum engine over a streamed grid.
//
// Use: write num_cols (index 0) and num_rows (index 1) through the plain
// write port while the block is idle; any write, even to an unused index,
// restarts the grid in progress. A size of 0 acts as 1 and a size above
// MAX_COLS / MAX_ROWS acts as that maximum. Send cell costs in row-major
// order on the input channel (i_valid / o_ready). After the bottom-right
// cell the minimum path sum of the grid comes out on the output channel
// (o_valid / i_ready) and the next item starts a fresh grid.
//
// Throughput: one item per cycle while no result waits on a low i_ready, set
// by the single add-and-compare stage and the shift line of row buffer cells,
// which advances one cell per item. The result register loads as the last item is accepted.
//
// The row of sums above lives in a chain of MAX_COLS cells; each new sum
// enters at cell MAX_COLS - cols and reaches the end just in time to be
// read as "above" by the same column of the next row.
//
// Reset: counters, left sum and the output valid clear at once; no clearing
// pass is needed since the first row writes every entry later rows read.
// Stall: while a result waits on a low i_ready, input is held off; a taken
// result frees the slot in the same cycle, so items keep flowing.
module grid_min_path_sum_row_buffer_top import gmps_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [COST_W-1:0] i_cell_cost,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [PATH_W-1:0] o_path_sum
);

    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CEW   = $clog2(MAX_COLS + 1);
    localparam int REW   = $clog2(MAX_ROWS + 1);
    // Worst path touches MAX_COLS + MAX_ROWS - 1 cells of full-scale cost.
    localparam int SUM_W = COST_W + $clog2(MAX_COLS + MAX_ROWS) + 1;
    localparam int EXT_W = (SUM_W > PATH_W) ? SUM_W : PATH_W;
    localparam logic signed [EXT_W-1:0] PATH_MAX =
        EXT_W'((64'sd1 <<< (PATH_W - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] PATH_MIN =
        EXT_W'(-(64'sd1 <<< (PATH_W - 1)));

    // Configuration registers.
    logic [CFG_W-1:0] r_num_cols;
    logic [CFG_W-1:0] r_num_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= CFG_W'(64);
            r_num_rows <= CFG_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the sizes into 1 .. MAX.
    logic [CEW-1:0] cols_eff;
    logic [REW-1:0] rows_eff;
    logic [CW-1:0]  ins_pos;

    always_comb begin
        if (r_num_cols == '0) begin
            cols_eff = CEW'(1);
        end else if (32'(r_num_cols) > MAX_COLS) begin
            cols_eff = CEW'(MAX_COLS);
        end else begin
            cols_eff = CEW'(r_num_cols);
        end
        if (r_num_rows == '0) begin
            rows_eff = REW'(1);
        end else if (32'(r_num_rows) > MAX_ROWS) begin
            rows_eff = REW'(MAX_ROWS);
        end else begin
            rows_eff = REW'(r_num_rows);
        end
        ins_pos = CW'(MAX_COLS - 32'(cols_eff));
    end

    // Handshake: accept while the output slot is empty or being emptied.
    logic accept;
    assign o_ready = !o_valid || i_ready;
    assign accept  = i_valid && o_ready;

    t_pos pos;

    gmps_pos #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (accept),
        .i_restart (i_cfg_we),
        .i_cols    (cols_eff),
        .i_rows    (rows_eff),
        .o_pos     (pos)
    );

    // Row buffer: a shift line of cells, advanced once per accepted item.
    logic [SUM_W-1:0] cell_sum [MAX_COLS];
    logic signed [SUM_W-1:0] new_sum;

    for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
        logic [SUM_W-1:0] prev;
        if (k == 0) begin : g_head
            assign prev = cell_sum[0];
        end else begin : g_body
            assign prev = cell_sum[k-1];
        end
        gmps_cell #(
            .WIDTH (SUM_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (accept),
            .i_load  (ins_pos == CW'(k)),
            .i_new   (new_sum),
            .i_prev  (prev),
            .o_sum   (cell_sum[k])
        );
    end

    // Best sum of the cell to the left.
    logic signed [SUM_W-1:0] r_left_sum;
    logic signed [SUM_W-1:0] above;
    logic signed [SUM_W-1:0] cost_ext;
    logic signed [SUM_W-1:0] base;

    always_comb begin
        above    = signed'(cell_sum[MAX_COLS-1]);
        cost_ext = SUM_W'(i_cell_cost);
        if (pos.first_row) begin
            base = pos.first_col ? '0 : r_left_sum;
        end else if (pos.first_col) begin
            base = above;
        end else begin
            base = (above < r_left_sum) ? above : r_left_sum;
        end
        new_sum = base + cost_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_sum <= '0;
        end else if (i_cfg_we) begin
            r_left_sum <= '0;
        end else if (accept) begin
            r_left_sum <= new_sum;
        end
    end

    // Saturate the final sum to the output width.
    logic signed [EXT_W-1:0] sum_ext;
    logic signed [EXT_W-1:0] sum_sat;

    always_comb begin
        sum_ext = EXT_W'(new_sum);
        if (sum_ext > PATH_MAX) begin
            sum_sat = PATH_MAX;
        end else if (sum_ext < PATH_MIN) begin
            sum_sat = PATH_MIN;
        end else begin
            sum_sat = sum_ext;
        end
    end

    // Output register: hold the result until it is taken.
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic signed [PATH_W-1:0] r_path_sum;
    logic signed [PATH_W-1:0] n_path_sum;
    logic                     done;

    assign done = accept && pos.last_col && pos.last_row;

    always_comb begin
        n_out_valid = r_out_valid;
        n_path_sum  = r_path_sum;
        if (done) begin
            n_out_valid = 1'b1;
            n_path_sum  = PATH_W'(sum_sat);
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_path_sum <= n_path_sum;
    end

    assign o_valid    = r_out_valid;
    assign o_path_sum = r_path_sum;

endmodule

FILE: sv/gmps_checker.sv
// Port-level checker for the grid path sum block, bound to its top level.
`include "grid_min_path_sum_row_buffer_top_defines.svh"

module gmps_checker import gmps_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_cfg_we,
    input logic [CFG_IDX_W-1:0]     i_cfg_index,
    input logic [CFG_W-1:0]         i_cfg_data,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic signed [COST_W-1:0] i_cell_cost,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic signed [PATH_W-1:0] o_path_sum
);

    // Reset empties the output slot.
    `GMPS_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_valid, "output valid after reset")

    // A stalled result holds its value.
    `GMPS_ASSERT(a_hold, o_valid && !i_ready |=> o_valid && $stable(o_path_sum), "result changed under stall")

    // An empty output slot never holds off input.
    `GMPS_ASSERT(a_ready_empty, !o_valid |-> o_ready, "input stalled with empty output")

    // A new result only follows an accepted item.
    `GMPS_ASSERT(a_cause, $rose(o_valid) |-> $past(i_valid && o_ready), "result without an item")

endmodule

bind grid_min_path_sum_row_buffer_top gmps_checker u_gmps_checker (.*);

FILE: tb/grid_min_path_sum_row_buffer_top_test.sv
// Self-checking testbench for the streamed grid minimum path sum block.
module grid_min_path_sum_row_buffer_top_test;
    import gmps_pkg::*;

    // Cycles to hold off after the last result before a register write or
    // the final verdict; the block holds its result in a register.
    localparam int DRAIN_CYCLES   = 4;
    // Cycles with no item, result or write accepted before giving up.
    localparam int WATCHDOG_LIMIT = 3000;
    // Saturation limits of the path_sum port.
    localparam int SUM_TOP = (1 << (PATH_W - 1)) - 1;
    localparam int SUM_BOT = -(1 << (PATH_W - 1));
    // Register indexes past the list: they only restart the grid.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [CFG_W-1:0]     SIZE_AT_RESET = 7'd64;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_W-1:0]         i_cfg_data;
    logic                     i_valid;
    logic                     o_ready;
    logic signed [COST_W-1:0] i_cell_cost;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [PATH_W-1:0] o_path_sum;

    // Percent of cycles in which the sender holds off / the receiver stalls.
    int send_idle_pct;
    int recv_idle_pct;
    // Tracks what i_valid was last scheduled to, so it is never assigned twice in a step.
    bit valid_up;
    int mismatch_count;
    int idle_cycles = 0;

    // Predicted path sums of completed grids, oldest first.
    logic signed [PATH_W-1:0] path_sums_due[$];

    // Predictor state: size registers, row of best sums above, left sum, position.
    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_reg;
    int               best_above [DEF_MAX_COLS];
    int               left_best;
    int               col_pos;
    int               row_pos;

    grid_min_path_sum_row_buffer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cell_cost (i_cell_cost),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_path_sum  (o_path_sum)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Size as the block uses it: zero acts as one, anything past the maximum as the maximum.
    function automatic int eff_size(input logic [CFG_W-1:0] raw, input int lim);
        if (raw == '0)
            return 1;
        if (int'(raw) > lim)
            return lim;
        return int'(raw);
    endfunction

    function automatic void restart_grid();
        left_best = 0;
        col_pos   = 0;
        row_pos   = 0;
    endfunction

    // Advance the predicted grid by one cell; return 1 with the grid's
    // minimum path sum when the cell is the bottom-right one.
    function automatic bit take_cell(input logic signed [COST_W-1:0] cost,
                                     output logic signed [PATH_W-1:0] grid_sum);
        int run_sum;
        int ncols;
        int nrows;
        ncols    = eff_size(cols_reg, DEF_MAX_COLS);
        nrows    = eff_size(rows_reg, DEF_MAX_ROWS);
        grid_sum = '0;
        if (row_pos == 0) begin
            // Top row: only the left neighbor feeds in.
            run_sum = (col_pos == 0) ? int'(cost) : left_best + int'(cost);
        end else if (col_pos == 0) begin
            // Left column: only the cell above feeds in.
            run_sum = best_above[col_pos] + int'(cost);
        end else begin
            run_sum = ((best_above[col_pos] < left_best) ? best_above[col_pos] : left_best)
                      + int'(cost);
        end
        best_above[col_pos] = run_sum;
        left_best           = run_sum;
        if (col_pos + 1 >= ncols) begin
            col_pos = 0;
            if (row_pos + 1 >= nrows) begin
                row_pos = 0;
                if (run_sum > SUM_TOP)
                    run_sum = SUM_TOP;
                else if (run_sum < SUM_BOT)
                    run_sum = SUM_BOT;
                grid_sum = PATH_W'(run_sum);
                return 1'b1;
            end
            row_pos++;
        end else begin
            col_pos++;
        end
        return 1'b0;
    endfunction

    // Scoreboard: check each accepted result against the oldest prediction,
    // then track register writes and accepted items, all from the values
    // present at the clock edge.
    always @(posedge i_clk) begin : scoreboard
        logic signed [PATH_W-1:0] want;
        logic signed [PATH_W-1:0] grid_sum;
        if (!i_rst_n) begin
            cols_reg = SIZE_AT_RESET;
            rows_reg = SIZE_AT_RESET;
            foreach (best_above[c])
                best_above[c] = 0;
            restart_grid();
            path_sums_due.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (path_sums_due.size() == 0) begin
                    $display("%0t: path_sum with none pending: expected none, actual %0d",
                             $time, o_path_sum);
                    mismatch_count++;
                end else begin
                    want = path_sums_due.pop_front();
                    if (o_path_sum !== want) begin
                        $display("%0t: path_sum mismatch: expected %0d, actual %0d",
                                 $time, want, o_path_sum);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_COLS: cols_reg = i_cfg_data;
                    CFG_NUM_ROWS: rows_reg = i_cfg_data;
                    default: ;
                endcase
                // Any write drops the grid in progress.
                restart_grid();
            end
            if (i_valid && o_ready) begin
                if (take_cell(i_cell_cost, grid_sum))
                    path_sums_due.push_back(grid_sum);
            end
        end
    end

    // Receiver: stall at random at the current rate.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: end the run if nothing is accepted for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("grid_min_path_sum_row_buffer_top_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Lower valid only if it is up, so it never gets two assignments in one step.
    task automatic drop_valid();
        if (valid_up) begin
            i_valid  <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    // Send one cell cost; return at the edge where it is accepted.
    task automatic send_cell(input logic signed [COST_W-1:0] cost);
        while ($urandom_range(99) < send_idle_pct) begin
            drop_valid();
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        valid_up    = 1'b1;
        i_cell_cost <= cost;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    // Hold input off until every predicted result has come, then let the block drain.
    task automatic settle_block();
        drop_valid();
        do
            @(posedge i_clk);
        while (path_sums_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one register while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        settle_block();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random cost, biased toward the extremes and toward small values that make ties.
    function automatic logic signed [COST_W-1:0] pick_cost();
        case ($urandom_range(7))
            0: return {1'b0, {(COST_W-1){1'b1}}};
            1: return {1'b1, {(COST_W-1){1'b0}}};
            2: return COST_W'($signed($urandom_range(6)) - 3);
            default: return COST_W'($urandom());
        endcase
    endfunction

    task automatic send_random_cells(input int count);
        repeat (count) send_cell(pick_cost());
    endtask

    // Columns at their reset size (64) with two rows: the whole row buffer
    // chain in use, every cell at the top and then at the bottom of the cost
    // range to drive the path sum to large magnitudes.
    task automatic test_reset_size_grids();
        write_reg(CFG_NUM_ROWS, 7'd2);
        repeat (2 * DEF_MAX_COLS) send_cell(16'sh7FFF);
        repeat (2 * DEF_MAX_COLS) send_cell(16'sh8000);
    endtask

    // 1 x 1 grids: each cell is a whole grid; walk the cost extremes and bit patterns.
    task automatic test_single_cell_grids();
        logic signed [COST_W-1:0] corner_costs [7] = '{16'sh0000, 16'sh7FFF, 16'sh8000,
            16'shFFFF, 16'sh0001, 16'sh5555, 16'shAAAA};
        write_reg(CFG_NUM_COLS, 7'd1);
        write_reg(CFG_NUM_ROWS, 7'd1);
        foreach (corner_costs[k])
            send_cell(corner_costs[k]);
    endtask

    // 3 x 3 grids where the best path turns both ways, with ties and extremes inside.
    task automatic test_small_grid_paths();
        logic signed [COST_W-1:0] turn_costs [9]  = '{1, 3, 1, 1, 5, 1, 4, 2, 1};
        logic signed [COST_W-1:0] mixed_costs [9] = '{-5, 2, -1, 3, 16'sh8000, 4,
            16'sh7FFF, -2, 0};
        write_reg(CFG_NUM_COLS, 7'd3);
        write_reg(CFG_NUM_ROWS, 7'd3);
        foreach (turn_costs[k])
            send_cell(turn_costs[k]);
        foreach (mixed_costs[k])
            send_cell(mixed_costs[k]);
    endtask

    // Out-of-range sizes: zero acts as one, past the maximum acts as the maximum.
    task automatic test_size_clamping();
        write_reg(CFG_NUM_COLS, 7'd0);
        write_reg(CFG_NUM_ROWS, 7'd127);
        send_random_cells(DEF_MAX_ROWS);
        write_reg(CFG_NUM_COLS, 7'd127);
        write_reg(CFG_NUM_ROWS, 7'd0);
        send_random_cells(DEF_MAX_COLS);
        write_reg(CFG_NUM_COLS, 7'd65);
        write_reg(CFG_NUM_ROWS, 7'd2);
        send_random_cells(2 * DEF_MAX_COLS);
    endtask

    // Writes mid-grid, to spare indexes and to a register with its own value,
    // drop the partial grid; the next full grid must come out clean.
    task automatic test_restart_on_write();
        write_reg(CFG_NUM_COLS, 7'd4);
        write_reg(CFG_NUM_ROWS, 7'd3);
        send_random_cells(5);
        write_reg(CFG_SPARE_A, 7'h55);
        send_random_cells(12);
        send_random_cells(7);
        write_reg(CFG_SPARE_B, 7'h2A);
        send_random_cells(12);
        send_random_cells(2);
        write_reg(CFG_NUM_COLS, 7'd4);
        send_random_cells(12);
    endtask

    // Random grids: mostly small sizes, now and then one long side or an
    // out-of-range size, several grids back to back per setting, and
    // occasionally a grid cut short by a write.
    task automatic test_random_grids(input int target);
        int               sent;
        int               cells;
        logic [CFG_W-1:0] cols_raw;
        logic [CFG_W-1:0] rows_raw;
        sent = 0;
        while (sent < target) begin
            case ($urandom_range(9))
                0: begin
                    cols_raw = CFG_W'($urandom_range(33, 127));
                    rows_raw = CFG_W'($urandom_range(0, 3));
                end
                1: begin
                    cols_raw = CFG_W'($urandom_range(0, 3));
                    rows_raw = CFG_W'($urandom_range(33, 127));
                end
                default: begin
                    cols_raw = CFG_W'($urandom_range(1, 8));
                    rows_raw = CFG_W'($urandom_range(1, 8));
                end
            endcase
            write_reg(CFG_NUM_COLS, cols_raw);
            write_reg(CFG_NUM_ROWS, rows_raw);
            cells = eff_size(cols_raw, DEF_MAX_COLS) * eff_size(rows_raw, DEF_MAX_ROWS);
            repeat ($urandom_range(1, 4)) begin
                send_random_cells(cells);
                sent += cells;
            end
            if (cells > 1 && $urandom_range(7) == 0) begin
                send_random_cells($urandom_range(1, cells - 1));
                write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_W'($urandom()));
            end
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        i_valid        <= 1'b0;
        i_cell_cost    <= '0;
        i_ready        <= 1'b0;
        valid_up       = 1'b0;
        mismatch_count = 0;
        send_idle_pct  = 24;
        recv_idle_pct  = 69;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_size_grids();
        test_single_cell_grids();
        test_small_grid_paths();
        test_size_clamping();
        test_restart_on_write();
        test_random_grids(50);

        // Swap who idles, then run with no idling at all.
        send_idle_pct = 69;
        recv_idle_pct = 24;
        test_random_grids(50);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_grids(50);

        settle_block();
        if (mismatch_count == 0 && path_sums_due.size() == 0)
            $display("grid_min_path_sum_row_buffer_top_test passed");
        else
            $display("grid_min_path_sum_row_buffer_top_test failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/gmps_pkg.sv
sv/gmps_cell.sv
sv/gmps_pos.sv
sv/grid_min_path_sum_row_buffer_top.sv
sv/gmps_checker.sv
tb/grid_min_path_sum_row_buffer_top_test.sv
